// File: rtl/core/stw_pkg.sv
package stw_pkg;

  localparam int DEPTH       = 1024;
  localparam int ELEM_BITS   = 16;
  localparam int VALUE_BITS  = 16;
  localparam int ADDR_BITS   = $clog2(DEPTH);
  localparam int IDX_BITS    = $clog2(DEPTH + 1);
  localparam int TARGET_BITS = 32;
  localparam int SUM_BITS    = TARGET_BITS + 1;
  localparam int FIRST_BITS  = 11;
  localparam int LAST_BITS   = 10;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  set_end;
  } in_word_t;

  typedef struct packed {
    logic                  found;
    logic [FIRST_BITS-1:0] first_index;
    logic [LAST_BITS-1:0]  last_index;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CHECK,
    ST_SUB,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic add;
    logic shrink_rd;
    logic shrink_sub;
    logic check;
    logic retire;
  } ctrl_cmd_t;

  typedef struct packed {
    logic active;
    logic shrink;
    logic emit_needed;
    logic out_free;
  } ctrl_stat_t;

endpackage

// File: rtl/core/stw_ram.sv
module stw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/stw_ctrl.sv
module stw_ctrl import stw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        state_nxt = stat.active ? ST_CHECK : ST_EMIT;
      end
      ST_CHECK: begin
        state_nxt = stat.shrink ? ST_SUB : ST_EMIT;
      end
      ST_SUB: begin
        state_nxt = ST_CHECK;
      end
      ST_EMIT: begin
        if (!stat.emit_needed || stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_ADD: begin
        cmd.add = stat.active;
      end
      ST_CHECK: begin
        cmd.shrink_rd = stat.shrink;
        cmd.check     = !stat.shrink;
      end
      ST_SUB: begin
        cmd.shrink_sub = 1'b1;
      end
      ST_EMIT: begin
        cmd.retire = !stat.emit_needed || stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_sub_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUB) |-> $past(cmd.shrink_rd))
    else $error("subtract step without a preceding read");

  a_accept_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_ADD))
    else $error("accepted word did not enter the add step");
`endif

endmodule

// File: rtl/core/stw_datapath.sv
module stw_datapath import stw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  in_word_t               in_word,
  input  logic                   cfg_we,
  input  logic [TARGET_BITS-1:0] cfg_wdata,
  output out_word_t              out_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  ctrl_cmd_t              cmd,
  output ctrl_stat_t             stat
);

  logic [TARGET_BITS-1:0] target_r,     target_nxt;
  logic [ELEM_BITS-1:0]   elem_r,       elem_nxt;
  logic                   last_r,       last_nxt;
  logic                   hit_r,        hit_nxt;
  logic [IDX_BITS-1:0]    front_r,      front_nxt;
  logic [IDX_BITS-1:0]    back_r,       back_nxt;
  logic [SUM_BITS-1:0]    sum_r,        sum_nxt;
  logic                   match_done_r, match_done_nxt;
  logic                   out_valid_r,  out_valid_nxt;
  out_word_t              out_word_r,   out_word_nxt;
  logic [ELEM_BITS-1:0]   rd_data;
  logic [IDX_BITS-1:0]    back_m1;
  logic                   load_out;

  stw_ram #(
    .WIDTH(ELEM_BITS),
    .DEPTH(DEPTH)
  ) u_window (
    .clk    (clk),
    .wr_en  (cmd.add),
    .wr_addr(back_r[ADDR_BITS-1:0]),
    .wr_data(elem_r),
    .rd_en  (cmd.shrink_rd),
    .rd_addr(front_r[ADDR_BITS-1:0]),
    .rd_data(rd_data)
  );

  assign back_m1 = back_r - IDX_BITS'(1);

  assign stat.active      = !match_done_r && (back_r < IDX_BITS'(DEPTH));
  assign stat.shrink      = (sum_r > SUM_BITS'(target_r)) && (front_r < back_r);
  assign stat.emit_needed = hit_r || (last_r && !match_done_r);
  assign stat.out_free    = !out_valid_r || out_ready;

  assign load_out = cmd.retire && stat.emit_needed;

  always_comb begin
    target_nxt     = cfg_we ? cfg_wdata : target_r;
    elem_nxt       = elem_r;
    last_nxt       = last_r;
    hit_nxt        = hit_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    sum_nxt        = sum_r;
    match_done_nxt = match_done_r;
    out_word_nxt   = out_word_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (cmd.accept) begin
      elem_nxt = in_word.value[ELEM_BITS-1:0];
      last_nxt = in_word.set_end;
      hit_nxt  = 1'b0;
    end
    if (cmd.add) begin
      sum_nxt  = sum_r + SUM_BITS'(elem_r);
      back_nxt = back_r + IDX_BITS'(1);
    end
    if (cmd.shrink_sub) begin
      sum_nxt   = sum_r - SUM_BITS'(rd_data);
      front_nxt = front_r + IDX_BITS'(1);
    end
    if (cmd.check) begin
      hit_nxt = (sum_r == SUM_BITS'(target_r));
    end
    if (load_out) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.found       = hit_r;
      out_word_nxt.first_index = hit_r ? FIRST_BITS'(front_r) : '0;
      out_word_nxt.last_index  = hit_r ? LAST_BITS'(back_m1) : '0;
    end
    if (cmd.retire) begin
      if (last_r) begin
        front_nxt      = '0;
        back_nxt       = '0;
        sum_nxt        = '0;
        match_done_nxt = 1'b0;
      end else if (hit_r) begin
        match_done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= '0;
      hit_r        <= 1'b0;
      last_r       <= 1'b0;
      front_r      <= '0;
      back_r       <= '0;
      sum_r        <= '0;
      match_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      target_r     <= target_nxt;
      hit_r        <= hit_nxt;
      last_r       <= last_nxt;
      front_r      <= front_nxt;
      back_r       <= back_nxt;
      sum_r        <= sum_nxt;
      match_done_r <= match_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elem_r     <= elem_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_front_behind_back: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= back_r)
    else $error("window front passed its back");

  a_no_add_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add |-> (!match_done_r && (back_r < IDX_BITS'(DEPTH))))
    else $error("element added after a match or past the window depth");

  a_hit_reports_found: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && hit_r) |=> (out_valid_r && out_word_r.found))
    else $error("match was not reported as found");
`endif

endmodule

// File: rtl/core/subarray_target_sum_window.sv
// Searches each set of non-negative elements for a contiguous run whose sum equals
// target_sum. Elements arrive as words on the in_ channel (valid/ready), with
// set_end marking the final element of a set. At most one word per set leaves on
// the out_ channel: found with the run's first and last index at the first match,
// or found cleared at the set's end when no run matched.
// Each element passes the idle, add, check and emit states (check only while the
// window is active), plus a read and a subtract step per element dropped from the
// window front, as the window RAM's single read port fetches one old element per
// drop and the subtraction waits on the registered read. No element drops twice.
// The result word is held in an output register, and the next input word is taken
// while that result waits. If the receiver stalls while an earlier result is
// still held, the block waits before retiring the next result and takes no input
// meanwhile. target_sum is written through cfg_we and cfg_wdata; the user must do
// so only while the block is idle, as the block does not enforce it. Synchronous
// reset clears target_sum, the window indices and the running sum; the window RAM
// needs no clearing pass.
module subarray_target_sum_window import stw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_word,
  input  logic                   cfg_we,
  input  logic [TARGET_BITS-1:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  stw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  stw_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_word (out_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
